[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while the synchronous active-low reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: label");

// Clocked property that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");

`endif

[rtl/core/spbq_pkg.sv]
// Shared types and constants for the stereo peaking biquad core.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package spbq_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 24;
    localparam int NUM_CHANNELS   = 2;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
    // five products, each below 2^(PROD_BITS-1) in magnitude
    localparam int ACC_BITS       = PROD_BITS + 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [ACC_BITS-1:0]    t_acc;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FF_GAIN_0 = 3'd0,
        REG_FF_GAIN_1 = 3'd1,
        REG_FF_GAIN_2 = 3'd2,
        REG_FB_GAIN_1 = 3'd3,
        REG_FB_GAIN_2 = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        t_coef ff_gain_0;
        t_coef ff_gain_1;
        t_coef ff_gain_2;
        t_coef fb_gain_1;
        t_coef fb_gain_2;
    } t_coef_set;

    typedef struct packed {
        t_sample prev_in_1;
        t_sample prev_in_2;
        t_sample prev_out_1;
        t_sample prev_out_2;
    } t_hist;

    // unity gain in Q8.24
    localparam t_coef COEF_ONE = COEF_BITS'(64'sd1 <<< COEF_FRAC_BITS);
    localparam t_coef COEF_ZERO = '0;

    localparam t_acc ROUND_HALF = ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam t_acc SAT_MAX    = ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam t_acc SAT_MIN    = ACC_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

endpackage

[rtl/core/stereo_peaking_biquad_core.sv]
// An accepted item waits in the input register, then moves to the result register,
// which the receiver drains. Throughput: one item per cycle on either channel while
// the output is not stalled; the combinational multiply-accumulate path from the
// input register to the result register sets this, and the history is updated at
// the same edge that loads the result, so same-channel items chain.
// Reset (i_rst_n low at an edge): empties both registers, zeroes both channels'
// history and loads ff_gain_0 = 1.0, other coefficients 0.
`timescale 1ns / 1ps

module stereo_peaking_biquad_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [spbq_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [spbq_pkg::COEF_BITS-1:0]     i_cfg_wdata,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [spbq_pkg::SAMPLE_BITS-1:0] i_audio_sample,
    input  logic                               i_channel_select,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [spbq_pkg::SAMPLE_BITS-1:0] o_filtered_sample,
    output logic                               o_out_channel
);

    spbq_pkg::t_coef_set coefs;
    spbq_pkg::t_hist     hist;
    spbq_pkg::t_sample   y_calc;

    logic                r_in_valid;
    spbq_pkg::t_sample   r_x;
    logic                r_ch;
    logic                r_out_valid;
    spbq_pkg::t_sample   r_y;
    logic                r_out_ch;

    logic                advance;
    logic                load_in;
    logic                upd;

    // result register may take a new item when empty or being drained
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign load_in = i_valid && !o_stall;
    assign upd     = r_in_valid && advance;

    spbq_coef_regs u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coefs     (coefs)
    );

    spbq_history u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .i_ch    (r_ch),
        .i_x     (r_x),
        .i_y     (y_calc),
        .o_hist  (hist)
    );

    spbq_datapath u_datapath (
        .i_x     (r_x),
        .i_hist  (hist),
        .i_coefs (coefs),
        .o_y     (y_calc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_x  <= i_audio_sample;
            r_ch <= i_channel_select;
        end
        if (upd) begin
            r_y      <= y_calc;
            r_out_ch <= r_ch;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_filtered_sample = r_y;
    assign o_out_channel     = r_out_ch;

endmodule

[rtl/core/spbq_coef_regs.sv]
// Coefficient register bank, written through the plain configuration port.
// Depends on spbq_pkg.
`timescale 1ns / 1ps

module spbq_coef_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spbq_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [spbq_pkg::COEF_BITS-1:0]     i_cfg_wdata,
    output spbq_pkg::t_coef_set               o_coefs
);

    spbq_pkg::t_coef_set r_coefs;
    spbq_pkg::t_coef_set n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_we) begin
            case (spbq_pkg::t_cfg_reg'(i_cfg_addr))
                spbq_pkg::REG_FF_GAIN_0: n_coefs.ff_gain_0 = i_cfg_wdata;
                spbq_pkg::REG_FF_GAIN_1: n_coefs.ff_gain_1 = i_cfg_wdata;
                spbq_pkg::REG_FF_GAIN_2: n_coefs.ff_gain_2 = i_cfg_wdata;
                spbq_pkg::REG_FB_GAIN_1: n_coefs.fb_gain_1 = i_cfg_wdata;
                spbq_pkg::REG_FB_GAIN_2: n_coefs.fb_gain_2 = i_cfg_wdata;
                default:                 n_coefs = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff_gain_0 <= spbq_pkg::COEF_ONE;
            r_coefs.ff_gain_1 <= spbq_pkg::COEF_ZERO;
            r_coefs.ff_gain_2 <= spbq_pkg::COEF_ZERO;
            r_coefs.fb_gain_1 <= spbq_pkg::COEF_ZERO;
            r_coefs.fb_gain_2 <= spbq_pkg::COEF_ZERO;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

[rtl/core/spbq_history.sv]
// Per-channel delay lines: last two inputs and last two outputs of each channel.
// Depends on spbq_pkg.
`timescale 1ns / 1ps

module spbq_history (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_upd,
    input  logic                i_ch,
    input  spbq_pkg::t_sample   i_x,
    input  spbq_pkg::t_sample   i_y,
    output spbq_pkg::t_hist     o_hist
);

    spbq_pkg::t_hist r_hist [spbq_pkg::NUM_CHANNELS];
    spbq_pkg::t_hist n_entry;

    // shift the selected channel's taps by one sample
    always_comb begin
        n_entry.prev_in_2  = r_hist[i_ch].prev_in_1;
        n_entry.prev_in_1  = i_x;
        n_entry.prev_out_2 = r_hist[i_ch].prev_out_1;
        n_entry.prev_out_1 = i_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < spbq_pkg::NUM_CHANNELS; c++) begin
                r_hist[c] <= '0;
            end
        end else if (i_upd) begin
            r_hist[i_ch] <= n_entry;
        end
    end

    assign o_hist = r_hist[i_ch];

endmodule

[rtl/core/spbq_datapath.sv]
// Direct Form I arithmetic: five products, sum, round half up, saturate.
// Purely combinational; depends on spbq_pkg.
`timescale 1ns / 1ps

module spbq_datapath (
    input  spbq_pkg::t_sample   i_x,
    input  spbq_pkg::t_hist     i_hist,
    input  spbq_pkg::t_coef_set i_coefs,
    output spbq_pkg::t_sample   o_y
);

    logic signed [spbq_pkg::PROD_BITS-1:0] p_ff0;
    logic signed [spbq_pkg::PROD_BITS-1:0] p_ff1;
    logic signed [spbq_pkg::PROD_BITS-1:0] p_ff2;
    logic signed [spbq_pkg::PROD_BITS-1:0] p_fb1;
    logic signed [spbq_pkg::PROD_BITS-1:0] p_fb2;
    spbq_pkg::t_acc                        acc;
    spbq_pkg::t_acc                        shifted;

    assign p_ff0 = i_coefs.ff_gain_0 * i_x;
    assign p_ff1 = i_coefs.ff_gain_1 * i_hist.prev_in_1;
    assign p_ff2 = i_coefs.ff_gain_2 * i_hist.prev_in_2;
    assign p_fb1 = i_coefs.fb_gain_1 * i_hist.prev_out_1;
    assign p_fb2 = i_coefs.fb_gain_2 * i_hist.prev_out_2;

    // exact sum; feedback terms are subtracted
    assign acc = spbq_pkg::ACC_BITS'(p_ff0) + spbq_pkg::ACC_BITS'(p_ff1)
               + spbq_pkg::ACC_BITS'(p_ff2) - spbq_pkg::ACC_BITS'(p_fb1)
               - spbq_pkg::ACC_BITS'(p_fb2) + spbq_pkg::ROUND_HALF;

    // arithmetic shift floors, so ties go toward plus infinity
    assign shifted = acc >>> spbq_pkg::COEF_FRAC_BITS;

    always_comb begin
        if (shifted > spbq_pkg::SAT_MAX) begin
            o_y = spbq_pkg::SAMPLE_BITS'(spbq_pkg::SAT_MAX);
        end else if (shifted < spbq_pkg::SAT_MIN) begin
            o_y = spbq_pkg::SAMPLE_BITS'(spbq_pkg::SAT_MIN);
        end else begin
            o_y = shifted[spbq_pkg::SAMPLE_BITS-1:0];
        end
    end

endmodule

[rtl/core/spbq_checker.sv]
// Port-level checker for the stereo peaking biquad core, bound to the top level.
// Depends on spbq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spbq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [spbq_pkg::SAMPLE_BITS-1:0]   o_filtered_sample,
    input logic                               o_out_channel
);

    // a held result stays offered
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)

    // a held result keeps its payload
    `ASSERT_CLK(a_out_data_hold, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_filtered_sample))
    `ASSERT_CLK(a_out_ch_hold, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_out_channel))

    // back-pressure upstream only while a result is stuck at the output
    `ASSERT_CLK(a_stall_needs_full, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

    // reset empties the output
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall)

endmodule

bind stereo_peaking_biquad_core spbq_checker u_spbq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_filtered_sample (o_filtered_sample),
    .o_out_channel     (o_out_channel)
);
